@@ hw/rtl/spi_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the spectral peak interpolator.
// No dependencies.
package spi_pkg;

  localparam int DIV_N = 26;
  localparam int LOG_N = 20;

  localparam logic REG_FREQ_STEP    = 1'b0;
  localparam logic REG_WINDOW_SCALE = 1'b1;

  localparam logic signed [23:0] LEVEL_FLOOR = -24'sd6313048;
  localparam logic signed [23:0] LEVEL_FULL  = -24'sd1;
  localparam logic [24:0] DB_LIMIT  = 25'd6313048;
  localparam logic [30:0] DB_Q28    = 31'd1616142483;
  localparam logic [15:0] WSCALE_RST = 16'd28623;
  localparam logic [23:0] FREQ_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic [26:0] sum;
    logic [26:0] rem;
    logic [25:0] low;
    logic [25:0] q;
  } div_st_t;

  typedef struct packed {
    logic [30:0] m;
    logic [19:0] frac;
  } log_st_t;

  typedef struct packed {
    logic        isp;
    logic        neg;
    logic [12:0] k;
    logic [24:0] c;
    logic [26:0] twoc;
    logic [23:0] freq;
    logic        faint;
    logic        full;
    logic [4:0]  msb;
  } side_t;

  function automatic logic [4:0] msb_of(logic [23:0] x);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/spi_div_cell.sv @@
`timescale 1ns / 1ps
// One restoring-division cell: resolves one quotient bit per cycle while en is high.
// Depends on spi_pkg.
module spi_div_cell import spi_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic    clk,
  input  logic    en,
  input  div_st_t st_i,
  output div_st_t st_o
);

  div_st_t    st_r;
  div_st_t    st_nxt;
  logic [27:0] t;
  logic        ge;

  always_comb begin
    t  = {st_i.rem, st_i.low[BIT]};
    ge = t >= {1'b0, st_i.sum};
    st_nxt      = st_i;
    st_nxt.rem  = ge ? 27'(t - {1'b0, st_i.sum}) : t[26:0];
    st_nxt.q    = {st_i.q[24:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end

  assign st_o = st_r;

endmodule

@@ hw/rtl/spi_log_cell.sv @@
`timescale 1ns / 1ps
// One log2 cell: squares the Q30 mantissa and yields one fraction bit.
// Depends on spi_pkg.
module spi_log_cell import spi_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  log_st_t st_i,
  output log_st_t st_o
);

  log_st_t     st_r;
  log_st_t     st_nxt;
  logic [61:0] sq;
  logic [31:0] s;

  always_comb begin
    sq = 62'(st_i.m) * 62'(st_i.m);
    s  = sq[61:30];
    if (s[31]) begin
      st_nxt.m    = s[31:1];
      st_nxt.frac = {st_i.frac[18:0], 1'b1};
    end else begin
      st_nxt.m    = s[30:0];
      st_nxt.frac = {st_i.frac[18:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end

  assign st_o = st_r;

endmodule

@@ hw/rtl/spectral_peak_interpolator_core.sv @@
`timescale 1ns / 1ps
// Three-bin spectral peak interpolator, top level.
// Depends on spi_pkg, spi_div_cell, spi_log_cell.
//
// Takes one transaction per cycle while the chain is not held (see below) and
// presents each result at the end of a pipeline whose depth is set by the
// 26 divider cells (one quotient bit each), the 20 log cells (one squaring
// each) and ten register stages around them. The whole chain advances
// together and holds while a result waits on out_ready.
module spectral_peak_interpolator_core import spi_pkg::*; #(
  parameter int FFT_SIZE = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [12:0]        in_bin_index,
  input  logic [24:0]        in_mag_left,
  input  logic [24:0]        in_mag_centre,
  input  logic [24:0]        in_mag_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_peak,
  output logic [23:0]        out_peak_frequency,
  output logic signed [23:0] out_level_db,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam logic [23:0] FREQ_STEP_RST = 24'((64'd48000 * 64'd65536) / FFT_SIZE);
  localparam int ST_DIV0 = 2;
  localparam int ST_C    = ST_DIV0 + DIV_N;
  localparam int ST_D    = ST_C + 1;
  localparam int ST_E    = ST_D + 1;
  localparam int ST_F    = ST_E + 1;
  localparam int ST_G    = ST_F + 1;
  localparam int ST_LOG0 = ST_G + 1;
  localparam int ST_H    = ST_LOG0 + LOG_N;
  localparam int ST_I    = ST_H + 1;
  localparam int ST_O    = ST_I + 1;

  logic [23:0] freq_step_r;
  logic [15:0] wscale_r;
  logic        adv;
  logic [ST_O:0] v_r;
  side_t side_r   [0:ST_I];
  side_t side_nxt [0:ST_I];
  side_t side_in;

  logic [24:0] a_diff_r;
  logic [26:0] a_sum_r;
  logic [50:0] b_num_r;
  logic [26:0] b_sum_r;
  div_st_t div_s [0:DIV_N];
  logic [37:0] c_pos_r;
  logic [51:0] c_sq_r;
  logic [38:0] pos_c;
  logic [45:0] d_hi_r;
  logic [39:0] d_lo_r;
  logic [54:0] d_pk_r;
  logic [61:0] fsum_c;
  logic [23:0] freq_c;
  logic [30:0] e_peak_r;
  logic [23:0] f_peak_r;
  logic [30:0] g_m_r;
  log_st_t log_s [0:LOG_N];
  logic [24:0] h_neg_r;
  logic [55:0] i_db_r;
  logic [56:0] db_sum_c;
  logic [24:0] db_c;
  logic signed [23:0] lvl_c;

  logic               out_is_peak_r;
  logic [23:0]        out_freq_r;
  logic signed [23:0] out_level_r;

  assign adv      = !v_r[ST_O] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_step_r <= FREQ_STEP_RST;
      wscale_r    <= WSCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FREQ_STEP:    freq_step_r <= cfg_data;
        REG_WINDOW_SCALE: wscale_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[ST_O-1:0], in_valid};
    end
  end

  always_comb begin
    side_in       = '0;
    side_in.isp   = (in_mag_centre > in_mag_left) && (in_mag_centre > in_mag_right);
    side_in.neg   = in_mag_right < in_mag_left;
    side_in.k     = in_bin_index;
    side_in.c     = in_mag_centre;
    side_in.twoc  = 27'({in_mag_centre, 1'b0}) - 27'(in_mag_left) - 27'(in_mag_right);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_diff_r <= (in_mag_right < in_mag_left) ? in_mag_left - in_mag_right
                                                : in_mag_right - in_mag_left;
      a_sum_r  <= 27'(in_mag_left) + 27'(in_mag_centre) + 27'(in_mag_right);
      b_num_r  <= {41'(wscale_r) * 41'(a_diff_r), 10'b0};
      b_sum_r  <= a_sum_r;
    end
  end

  always_comb begin
    div_s[0].sum = b_sum_r;
    div_s[0].rem = {2'b0, b_num_r[50:26]};
    div_s[0].low = b_num_r[25:0];
    div_s[0].q   = '0;
  end

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    spi_div_cell #(.BIT(DIV_N - 1 - i)) u_cell (
      .clk  (clk),
      .en   (adv),
      .st_i (div_s[i]),
      .st_o (div_s[i+1])
    );
  end

  always_comb begin
    if (side_r[ST_C-1].neg) begin
      pos_c = {2'b0, side_r[ST_C-1].k, 24'b0} - {13'b0, div_s[DIV_N].q};
    end else begin
      pos_c = {2'b0, side_r[ST_C-1].k, 24'b0} + {13'b0, div_s[DIV_N].q};
    end
  end

  always_comb begin
    fsum_c = {d_hi_r, 16'b0} + 62'(d_lo_r) + (62'd1 << 31);
    freq_c = (|fsum_c[61:56]) ? FREQ_MAX : fsum_c[55:32];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_pos_r  <= pos_c[38] ? '0 : pos_c[37:0];
      c_sq_r   <= 52'(div_s[DIV_N].q) * 52'(div_s[DIV_N].q);
      d_hi_r   <= 46'(c_pos_r[37:16]) * 46'(freq_step_r);
      d_lo_r   <= 40'(c_pos_r[15:0]) * 40'(freq_step_r);
      d_pk_r   <= 55'(side_r[ST_D-1].twoc) * 55'(c_sq_r[51:24]);
      e_peak_r <= 31'(side_r[ST_E-1].c) + 31'(d_pk_r[54:25]);
      f_peak_r <= e_peak_r[23:0];
      g_m_r    <= 31'(f_peak_r) << (5'd30 - side_r[ST_G-1].msb);
    end
  end

  assign log_s[0].m    = g_m_r;
  assign log_s[0].frac = '0;

  for (genvar j = 0; j < LOG_N; j++) begin : g_log
    spi_log_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .st_i (log_s[j]),
      .st_o (log_s[j+1])
    );
  end

  always_comb begin
    db_sum_c = 57'(i_db_r) + (57'd1 << 31);
    db_c     = db_sum_c[56:32];
    lvl_c    = (db_c > DB_LIMIT) ? LEVEL_FLOOR : -$signed(24'(db_c));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_neg_r <= {5'd24 - side_r[ST_H-1].msb, 20'b0} - 25'(log_s[LOG_N].frac);
      i_db_r  <= 56'(h_neg_r) * 56'(DB_Q28);
      out_is_peak_r <= side_r[ST_I].isp;
      out_freq_r    <= side_r[ST_I].isp ? side_r[ST_I].freq : '0;
      if (!side_r[ST_I].isp || side_r[ST_I].faint) begin
        out_level_r <= LEVEL_FLOOR;
      end else if (side_r[ST_I].full) begin
        out_level_r <= LEVEL_FULL;
      end else begin
        out_level_r <= lvl_c;
      end
    end
  end

  always_comb begin
    for (int i = 0; i <= ST_I; i++) begin
      side_nxt[i] = (i == 0) ? side_in : side_r[(i == 0) ? 0 : i - 1];
    end
    side_nxt[ST_E].freq  = freq_c;
    side_nxt[ST_F].faint = e_peak_r < 31'd256;
    side_nxt[ST_F].full  = e_peak_r >= 31'd16777216;
    side_nxt[ST_F].msb   = msb_of(e_peak_r[23:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= ST_I; i++) side_r[i] <= side_nxt[i];
    end
  end

  assign out_valid          = v_r[ST_O];
  assign out_is_peak        = out_is_peak_r;
  assign out_peak_frequency = out_freq_r;
  assign out_level_db       = out_level_r;

endmodule

@@ hw/rtl/spi_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the spectral peak interpolator and their binding.
// Depends on spi_pkg and spectral_peak_interpolator_core.
module spi_checker import spi_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_is_peak,
  input logic [23:0]        out_peak_frequency,
  input logic signed [23:0] out_level_db
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level_db)
      && $stable(out_peak_frequency) && $stable(out_is_peak))
    else $error("stalled transaction changed");

  a_nopeak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_peak |-> out_peak_frequency == 24'd0
      && out_level_db == LEVEL_FLOOR)
    else $error("non-peak transaction not at floor");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_db <= 24'sd0 && out_level_db >= LEVEL_FLOOR)
    else $error("level out of range");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind spectral_peak_interpolator_core spi_checker u_spi_checker (.*);
